/* src/acrr_pkg.sv */
// Shared types and constants for the associative cache with round-robin eviction.
package acrr_pkg;

  localparam int KEY_W       = 48;
  localparam int VAL_W       = 16;
  localparam int REQ_W       = 2;
  localparam int ENTRIES_DEF = 64;

  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STORE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_INVAL  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value_out;
  } rsp_t;

endpackage

/* src/assoc_cache_round_robin_evict.sv */
// Fully associative key-to-value cache with round-robin eviction, top level.
//
// A request beat (in_req: operation, key, value) is taken at a rising edge where
// start is high and busy is low. Exactly one result beat follows on out_rsp,
// marked by out_valid for a single cycle; the receiver cannot stall it, so it
// must take every result in the cycle it appears.
// The table lives in one synchronous memory of ENTRIES words (key and value
// side by side) with a registered read. Lookup, store and invalidate scan the
// memory from entry 0 upwards, one word a cycle, with the next read issued
// while the previous word is compared. A store or invalidate writes the
// chosen entry back in the cycle of the compare. A request with key zero
// (other than clear) answers a miss from the idle state, without a scan, and
// leaves busy low. A clear-table request sweeps zeros through every entry,
// one a cycle, and then answers. The scan over the memory port holds the
// block to one request at a time: a new one is taken only when busy is low.
// Reset (rst_n low, synchronous) starts the same clearing pass: busy stays
// high until every entry is cleared, no result beat is given for it, and
// the victim pointer returns to entry 0.
module assoc_cache_round_robin_evict #(
  parameter int ENTRIES = acrr_pkg::ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  acrr_pkg::req_t in_req,
  output logic           out_valid,
  output acrr_pkg::rsp_t out_rsp
);

  localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WORD_W = acrr_pkg::KEY_W + acrr_pkg::VAL_W;
  localparam logic [AW-1:0] LAST  = AW'(ENTRIES - 1);
  localparam logic [AW:0]   DEPTH = (AW+1)'(ENTRIES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  // Table memory: key in the upper bits, value in the lower.
  logic [WORD_W-1:0] mem [ENTRIES];
  logic [WORD_W-1:0] rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [WORD_W-1:0] mem_wd;
  logic              mem_re;
  logic [AW-1:0]     mem_ra;

  logic [1:0]     state_r, state_nxt;
  logic [AW:0]    iss_r, iss_nxt;
  logic [AW-1:0]  chk_r, chk_nxt;
  logic           chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]  vp_r, vp_nxt;
  logic           clr_resp_r, clr_resp_nxt;
  acrr_pkg::req_t req_r, req_nxt;
  logic           out_valid_r, out_valid_nxt;
  acrr_pkg::rsp_t out_r, out_nxt;

  logic [acrr_pkg::KEY_W-1:0] target;
  logic [acrr_pkg::KEY_W-1:0] rd_key;
  logic [acrr_pkg::VAL_W-1:0] rd_val;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  assign rd_key = rd_data_r[WORD_W-1:acrr_pkg::VAL_W];
  assign rd_val = rd_data_r[acrr_pkg::VAL_W-1:0];
  // A store hunts for the first empty entry, the others for the key itself.
  assign target = (req_r.req_type == acrr_pkg::REQ_STORE) ? '0 : req_r.key;

  always_comb begin
    state_nxt     = state_r;
    iss_nxt       = iss_r;
    chk_nxt       = chk_r;
    chk_vld_nxt   = 1'b0;
    vp_nxt        = vp_r;
    clr_resp_nxt  = clr_resp_r;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    mem_we        = 1'b0;
    mem_wa        = chk_r;
    mem_wd        = '0;
    mem_re        = 1'b0;
    mem_ra        = iss_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt = in_req;
          if (in_req.req_type == acrr_pkg::REQ_CLEAR) begin
            state_nxt    = ST_CLEAR;
            iss_nxt      = '0;
            clr_resp_nxt = 1'b1;
            vp_nxt       = '0;
          end else if (in_req.key == '0) begin
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = ST_SCAN;
            iss_nxt   = '0;
          end
        end
      end

      ST_SCAN: begin
        // Issue the next read while the previous word is being compared.
        if (iss_r < DEPTH) begin
          mem_re      = 1'b1;
          iss_nxt     = iss_r + 1'b1;
          chk_nxt     = iss_r[AW-1:0];
          chk_vld_nxt = 1'b1;
        end
        if (chk_vld_r) begin
          if (rd_key == target) begin
            state_nxt     = ST_IDLE;
            chk_vld_nxt   = 1'b0;
            out_valid_nxt = 1'b1;
            out_nxt.found = 1'b1;
            case (req_r.req_type)
              acrr_pkg::REQ_LOOKUP: begin
                out_nxt.value_out = rd_val;
              end
              acrr_pkg::REQ_STORE: begin
                mem_we = 1'b1;
                mem_wd = {req_r.key, req_r.value_in};
              end
              default: begin
                mem_we = 1'b1;
              end
            endcase
          end else if (chk_r == LAST) begin
            state_nxt     = ST_IDLE;
            chk_vld_nxt   = 1'b0;
            out_valid_nxt = 1'b1;
            if (req_r.req_type == acrr_pkg::REQ_STORE) begin
              // Table full: overwrite the victim and move the pointer on.
              mem_we = 1'b1;
              mem_wa = vp_r;
              mem_wd = {req_r.key, req_r.value_in};
              vp_nxt = (vp_r == LAST) ? '0 : vp_r + 1'b1;
            end
          end
        end
      end

      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = iss_r[AW-1:0];
        iss_nxt = iss_r + 1'b1;
        if (iss_r[AW-1:0] == LAST) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = clr_resp_r;
          clr_resp_nxt  = 1'b0;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      iss_r       <= '0;
      chk_vld_r   <= 1'b0;
      vp_r        <= '0;
      clr_resp_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      chk_vld_r   <= chk_vld_nxt;
      vp_r        <= vp_nxt;
      clr_resp_r  <= clr_resp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r <= chk_nxt;
    req_r <= req_nxt;
    out_r <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

endmodule

/* src/acrr_checker.sv */
// Port-level checks for the associative cache, bound to its top level.
module acrr_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input acrr_pkg::req_t in_req,
  input logic           out_valid,
  input acrr_pkg::rsp_t out_rsp
);

  // Reset always starts the clearing pass, so the block is busy afterwards.
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy after reset");

  // A result beat only follows an accepted request or ongoing work.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result beat without a request");

  // A request with key zero, other than a clear, answers a miss at once.
  a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.req_type != acrr_pkg::REQ_CLEAR && in_req.key == '0)
      |=> (out_valid && !out_rsp.found && out_rsp.value_out == '0 && !busy))
    else $error("key zero request not answered as a miss");

  // A non-zero value is only ever returned together with a hit.
  a_value_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.value_out != '0) |-> out_rsp.found)
    else $error("value returned without a hit");

  // A clear-table request starts the sweep.
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.req_type == acrr_pkg::REQ_CLEAR) |=> (busy && !out_valid))
    else $error("clear request did not start the sweep");

endmodule

bind assoc_cache_round_robin_evict acrr_checker u_acrr_checker (.*);
